// ===== hw/rtl/spq_pkg.sv =====
package spq_pkg;

  // Queue geometry
  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int unsigned PAYLOAD_BITS = 32;

  // Stored payload width: the port carries 32 bits at most
  localparam int unsigned STORE_BITS = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int unsigned COUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Field widths on the stream ports
  localparam int unsigned PRI_W   = 2;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned PAY_W   = 32;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned IN_DW   = 72;
  localparam int unsigned OUT_DW  = 72;
  localparam int unsigned IN_UW   = 2;
  localparam int unsigned OUT_UW  = 3;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // One queue entry as held in a cell
  typedef struct packed {
    logic                  used;
    logic [PRI_W-1:0]      pri;
    logic [ID_W-1:0]       id;
    logic [STORE_BITS-1:0] payload;
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } op_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
module spq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spq_pkg::op_t    op_i,
  input  spq_pkg::entry_t new_i,        // entry being pushed
  input  spq_pkg::entry_t prev_i,       // neighbor toward the head
  input  logic            prev_take_i,  // neighbor toward the head takes or shifts
  input  spq_pkg::entry_t next_i,       // neighbor toward the tail
  output spq_pkg::entry_t entry_o,
  output logic            take_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;
  logic   ahead;

  // New key strictly ahead of the stored one; equal keys stay behind
  always_comb begin
    if (new_i.pri != entry_q.pri) begin
      ahead = new_i.pri < entry_q.pri;
    end else begin
      ahead = new_i.id < entry_q.id;
    end
  end

  assign take_o = !entry_q.used || ahead;

  // Insert, shift toward tail, shift toward head, or flush
  always_comb begin
    entry_d = entry_q;
    if (op_i.clear) begin
      entry_d.used = 1'b0;
    end else if (op_i.pop) begin
      entry_d = next_i;
    end else if (op_i.push && take_o) begin
      if (prev_take_i) begin
        entry_d = prev_i;
      end else begin
        entry_d      = new_i;
        entry_d.used = 1'b1;
      end
    end
  end

  // Occupancy flag, key and payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Channel | Dir | Fields
// s_axis  | in  | tuser: mode; tdata: in_priority, in_id, in_payload
// m_axis  | out | tuser: status, out_valid; tdata: out_priority, out_id,
//         |     |        out_payload, entry_count
//
// One item per cycle while no result waits untaken: every cell of the chain
// compares the pushed key with its own and loads, shifts or holds in that
// cycle; the result is in the output register on the next cycle.
// Reset empties the queue at once; no clearing pass.
// A result not taken holds the output register, and the input stalls until
// it leaves (same-cycle take and accept allowed).
module sorted_priority_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [spq_pkg::IN_DW-1:0]  s_axis_tdata,   // in_priority, in_id, in_payload, pad
  input  logic [spq_pkg::IN_UW-1:0]  s_axis_tuser,   // mode
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [spq_pkg::OUT_DW-1:0] m_axis_tdata,   // out_priority, out_id, out_payload,
                                                      // entry_count, pad
  output logic [spq_pkg::OUT_UW-1:0] m_axis_tuser    // status, out_valid
);
  import spq_pkg::*;

  logic               accept;
  mode_e              mode;
  logic [PRI_W-1:0]   in_pri;
  logic [ID_W-1:0]    in_id;
  logic [PAY_W-1:0]   in_pay;
  logic               full, empty;
  op_t                op;
  entry_t             new_entry;
  entry_t             cell_q     [QUEUE_DEPTH];
  logic               take       [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] used_vec;

  logic [COUNT_W-1:0] count_q, count_d;
  logic               ovalid_q;
  status_e            status_q, status_d;
  logic               pvalid_q, pvalid_d;
  logic [PRI_W-1:0]   opri_q, opri_d;
  logic [ID_W-1:0]    oid_q, oid_d;
  logic [PAY_W-1:0]   opay_q, opay_d;

  // Input unpacking
  assign mode   = mode_e'(s_axis_tuser[1:0]);
  assign in_pri = s_axis_tdata[1:0];
  assign in_id  = s_axis_tdata[33:2];
  assign in_pay = s_axis_tdata[65:34];

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = (count_q == COUNT_W'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  // Command to the chain
  always_comb begin
    op.push  = accept && (mode == MODE_PUSH) && !full;
    op.pop   = accept && (mode == MODE_POP) && !empty;
    op.clear = accept && (mode == MODE_CLEAR);
  end

  assign new_entry.used    = 1'b1;
  assign new_entry.pri     = in_pri;
  assign new_entry.id      = in_id;
  assign new_entry.payload = in_pay[STORE_BITS-1:0];

  // Row of compare-and-shift cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_t;
    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_t = 1'b0;
    end else begin : g_mid
      assign prev_e = cell_q[i-1];
      assign prev_t = take[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .op_i        (op),
      .new_i       (new_entry),
      .prev_i      (prev_e),
      .prev_take_i (prev_t),
      .next_i      (next_e),
      .entry_o     (cell_q[i]),
      .take_o      (take[i])
    );
    assign used_vec[i] = cell_q[i].used;
  end

  // Count and result of this item
  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    pvalid_d = 1'b0;
    opri_d   = '0;
    oid_d    = '0;
    opay_d   = '0;
    case (mode)
      MODE_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + COUNT_W'(1);
        end
      end
      MODE_POP: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d  = count_q - COUNT_W'(1);
          pvalid_d = 1'b1;
          opri_d   = cell_q[0].pri;
          oid_d    = cell_q[0].id;
          opay_d   = PAY_W'(cell_q[0].payload);
        end
      end
      MODE_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (s_axis_tready) begin
        ovalid_q <= accept;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      pvalid_q <= pvalid_d;
      opri_q   <= opri_d;
      oid_q    <= oid_d;
      opay_q   <= opay_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = {pvalid_q, status_q};
  assign m_axis_tdata  = {1'b0, CNT_W'(count_q), opay_q, oid_q, opri_q};

  // Occupied cells always equal the count
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(used_vec) == int'(count_q))
    else $error("cell occupancy differs from count");

  // Occupied cells form a prefix from the head
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((used_vec >> 1) & ~used_vec) == '0)
    else $error("gap in occupied cells");

  // A presented entry only comes with a done status
  a_valid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_DONE)
    else $error("popped entry with error status");

  // Clear leaves the queue empty
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode == MODE_CLEAR) |=> count_q == '0 && used_vec == '0)
    else $error("queue not empty after clear");

endmodule
